// File: sv/mis_pkg.sv
`default_nettype none

package mis_pkg;

	localparam int VALUE_W = 31;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH_ADDR,
		ST_SRCH_CMP,
		ST_SHIFT,
		ST_OUTPUT
	} mis_state_t;

endpackage

`default_nettype wire

// File: sv/merge_insertion_sorter.sv
// Channel   Transfer when            Signals
// input     start && !busy           value, last_in
// result    sorted_valid             sorted_value, last_out, overflowed
//
// Each value is placed by a binary search over the sorted store, then entries >= it move up.
// A search takes at most log2 of the count plus one steps (ST_SRCH_ADDR, then ST_SRCH_CMP),
// and the move shifts each such entry up; busy stays high until the value has been written.
// A value that arrives while the store is full is dropped without a search. After the last
// value of a batch, its n results are read out on consecutive cycles, which cannot be stalled.
// Reset clears the control state only; the store itself needs no clearing.
`default_nettype none

module merge_insertion_sorter #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [mis_pkg::VALUE_W-1:0] value,
	input  logic                        last_in,
	output logic                        sorted_valid,
	output logic [mis_pkg::VALUE_W-1:0] sorted_value,
	output logic                        last_out,
	output logic                        overflowed
);

	import mis_pkg::*;

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam logic [CW-1:0] CAP = CW'(MAX_ITEMS);

	mis_state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic          ovf_q, ovf_d;
	logic [VALUE_W-1:0] val_q;
	logic          last_q;
	logic          load;
	logic [CW-1:0] lo_q, lo_d;
	logic [CW-1:0] hi_q, hi_d;
	logic [AW-1:0] mid_q, mid_d;
	logic [CW-1:0] ptr_q, ptr_d;
	logic          pend_q, pend_d;
	logic          emit_s1, last_s1, ovf_s1;
	logic          emit_d, last_d;

	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid_full;
	logic [CW-1:0] ptr_m1, ptr_m2;

	logic               we;
	logic [AW-1:0]      wr_addr;
	logic [VALUE_W-1:0] wr_data;
	logic [AW-1:0]      rd_addr;
	logic [VALUE_W-1:0] rdata;

	mis_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(MAX_ITEMS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_full = mid_sum[CW:1];
	assign ptr_m1   = ptr_q - CW'(1);
	assign ptr_m2   = ptr_q - CW'(2);

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		ovf_d   = ovf_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		mid_d   = mid_q;
		ptr_d   = ptr_q;
		pend_d  = pend_q;
		load    = 1'b0;
		we      = 1'b0;
		wr_addr = ptr_q[AW-1:0];
		wr_data = rdata;
		rd_addr = ptr_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					load = 1'b1;
					if (count_q == CAP) begin
						// Store full: the value is dropped, the batch is marked.
						ovf_d = 1'b1;
						if (last_in) begin
							ptr_d   = '0;
							state_d = ST_OUTPUT;
						end
					end else begin
						lo_d    = '0;
						hi_d    = count_q;
						state_d = ST_SRCH_ADDR;
					end
				end
			end
			ST_SRCH_ADDR: begin
				if (lo_q < hi_q) begin
					mid_d   = mid_full[AW-1:0];
					rd_addr = mid_full[AW-1:0];
					state_d = ST_SRCH_CMP;
				end else begin
					ptr_d   = count_q;
					pend_d  = 1'b0;
					state_d = ST_SHIFT;
				end
			end
			ST_SRCH_CMP: begin
				if (rdata < val_q) begin
					lo_d = CW'(mid_q) + CW'(1);
				end else begin
					hi_d = CW'(mid_q);
				end
				state_d = ST_SRCH_ADDR;
			end
			ST_SHIFT: begin
				// lo_q holds the insertion slot. Reads run one entry ahead of
				// the writes, so each cycle moves one entry up by one place.
				if (ptr_q == lo_q) begin
					we      = 1'b1;
					wr_addr = lo_q[AW-1:0];
					wr_data = val_q;
					count_d = count_q + CW'(1);
					if (last_q) begin
						ptr_d   = '0;
						state_d = ST_OUTPUT;
					end else begin
						state_d = ST_IDLE;
					end
				end else if (!pend_q) begin
					rd_addr = ptr_m1[AW-1:0];
					pend_d  = 1'b1;
				end else begin
					we      = 1'b1;
					wr_addr = ptr_q[AW-1:0];
					wr_data = rdata;
					ptr_d   = ptr_m1;
					if (ptr_m1 != lo_q) begin
						rd_addr = ptr_m2[AW-1:0];
					end else begin
						pend_d = 1'b0;
					end
				end
			end
			ST_OUTPUT: begin
				rd_addr = ptr_q[AW-1:0];
				if (ptr_q == count_q) begin
					count_d = '0;
					ovf_d   = 1'b0;
					state_d = ST_IDLE;
				end else begin
					ptr_d = ptr_q + CW'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign emit_d = (state_q == ST_OUTPUT) && (ptr_q != count_q);
	assign last_d = (ptr_q == count_q - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
			last_q  <= 1'b0;
			lo_q    <= '0;
			hi_q    <= '0;
			mid_q   <= '0;
			ptr_q   <= '0;
			pend_q  <= 1'b0;
			emit_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ovf_q   <= ovf_d;
			lo_q    <= lo_d;
			hi_q    <= hi_d;
			mid_q   <= mid_d;
			ptr_q   <= ptr_d;
			pend_q  <= pend_d;
			emit_s1 <= emit_d;
			if (load) begin
				last_q <= last_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= value;
		end
		last_s1 <= last_d;
		ovf_s1  <= ovf_q;
	end

	assign busy         = (state_q != ST_IDLE);
	assign sorted_valid = emit_s1;
	assign sorted_value = rdata;
	assign last_out     = last_s1;
	assign overflowed   = ovf_s1;

endmodule

`default_nettype wire

// File: sv/mis_ram.sv
`default_nettype none

module mis_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: sv/mis_checker.sv
`default_nettype none

module mis_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        busy,
	input logic                        sorted_valid,
	input logic [mis_pkg::VALUE_W-1:0] sorted_value,
	input logic                        last_out,
	input logic                        overflowed
);

	// Results appear only while the block reports itself busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		sorted_valid |-> busy)
	else $error("result transfer while not busy");

	// A batch comes out as one unbroken run of transfers.
	assert property (@(posedge clk) disable iff (!arst_n)
		sorted_valid && !last_out |=> sorted_valid)
	else $error("gap inside a batch of results");

	// The block is free again right after the final result.
	assert property (@(posedge clk) disable iff (!arst_n)
		sorted_valid && last_out |=> !busy)
	else $error("still busy after the final result");

	// Within a batch values never decrease and the overflow mark does not change.
	assert property (@(posedge clk) disable iff (!arst_n)
		sorted_valid && $past(sorted_valid) && !$past(last_out) |->
			(sorted_value >= $past(sorted_value)) && (overflowed == $past(overflowed)))
	else $error("results out of order or overflow mark changed");

endmodule

bind merge_insertion_sorter mis_checker u_mis_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.busy        (busy),
	.sorted_valid(sorted_valid),
	.sorted_value(sorted_value),
	.last_out    (last_out),
	.overflowed  (overflowed)
);

`default_nettype wire

// File: tb/tb_merge_insertion_sorter.sv
`timescale 1ns / 1ps

module tb_merge_insertion_sorter;

	localparam int CAPACITY     = 64;
	localparam int RANDOM_ITEMS = 220;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 400000;

	typedef logic [mis_pkg::VALUE_W-1:0] value_t;

	localparam value_t VALUE_MAX = {mis_pkg::VALUE_W{1'b1}};

	typedef struct packed {
		value_t value;
		logic   last;
		logic   ovf;
	} sorted_result_t;

	typedef enum int {
		VAL_FULL,
		VAL_NARROW,
		VAL_EDGE
	} value_kind_t;

	typedef enum int {
		ORD_RANDOM,
		ORD_ASCENDING,
		ORD_DESCENDING
	} batch_order_t;

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	value_t value;
	logic   last_in;
	logic   sorted_valid;
	value_t sorted_value;
	logic   last_out;
	logic   overflowed;

	// Shadow of the block: the current batch kept in ascending order.
	value_t         held_vals[$];
	logic           held_ovf;
	sorted_result_t expected_q[$];
	sorted_result_t want;

	int  err_count;
	int  results_seen;
	int  items_sent;
	int  batches_done;
	int  ovf_batches;
	int  cycle_count;
	bit  no_idle;

	merge_insertion_sorter #(
		.MAX_ITEMS(CAPACITY)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.last_in(last_in),
		.sorted_valid(sorted_valid),
		.sorted_value(sorted_value),
		.last_out(last_out),
		.overflowed(overflowed)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycle_count, expected_q.size());
			$display("merge_insertion_sorter: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && sorted_valid) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				$error("Unexpected result: sorted_value=%0d last_out=%0b overflowed=%0b",
					sorted_value, last_out, overflowed);
				err_count++;
			end else begin
				want = expected_q.pop_front();
				if (sorted_value !== want.value) begin
					$error("sorted_value: expected %0d, actual %0d", want.value, sorted_value);
					err_count++;
				end
				if (last_out !== want.last) begin
					$error("last_out: expected %0b, actual %0b", want.last, last_out);
					err_count++;
				end
				if (overflowed !== want.ovf) begin
					$error("overflowed: expected %0b, actual %0b", want.ovf, overflowed);
					err_count++;
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99, 0);
		if (no_idle || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic value_t rand_value(input value_kind_t kind);
		value_t v;
		case (kind)
			VAL_NARROW: begin
				v = value_t'($urandom_range(7, 0));
			end
			VAL_EDGE: begin
				case ($urandom_range(4, 0))
					0: v = '0;
					1: v = value_t'(1);
					2: v = VALUE_MAX;
					3: v = VALUE_MAX - value_t'(1);
					default: v = value_t'(1) << $urandom_range(mis_pkg::VALUE_W - 1, 0);
				endcase
			end
			default: begin
				v = value_t'($urandom);
			end
		endcase
		return v;
	endfunction

	// Updates the shadow batch for one accepted value; the last value of a
	// batch releases the whole sorted batch as expectations.
	task automatic sorter_accept(input value_t v, input logic lst);
		int pos;
		sorted_result_t r;
		if (held_vals.size() >= CAPACITY) begin
			held_ovf = 1'b1;
		end else begin
			pos = 0;
			while (pos < held_vals.size() && held_vals[pos] < v)
				pos++;
			held_vals.insert(pos, v);
		end
		items_sent++;
		if (lst) begin
			for (int i = 0; i < held_vals.size(); i++) begin
				r.value = held_vals[i];
				r.last  = (i == held_vals.size() - 1);
				r.ovf   = held_ovf;
				expected_q.insert(expected_q.size(), r);
			end
			if (held_ovf)
				ovf_batches++;
			batches_done++;
			held_vals.delete();
			held_ovf = 1'b0;
		end
	endtask

	// Start stays high after a transfer so that back-to-back values need no
	// toggle; it drops only when a gap follows.
	task automatic push_value(input value_t v, input logic lst);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		value   <= v;
		last_in <= lst;
		do
			@(posedge clk);
		while (busy);
		sorter_accept(v, lst);
	endtask

	task automatic test_single_item_batches();
		push_value(VALUE_MAX, 1'b1);
		push_value('0, 1'b1);
		push_value(value_t'(1), 1'b1);
	endtask

	task automatic test_ordering_and_duplicates();
		push_value(value_t'(5), 1'b0);
		push_value(value_t'(3), 1'b0);
		push_value(VALUE_MAX, 1'b0);
		push_value('0, 1'b0);
		push_value(value_t'(1), 1'b0);
		push_value(value_t'(3), 1'b0);
		push_value(VALUE_MAX - value_t'(1), 1'b0);
		push_value(value_t'(3), 1'b1);
		for (int i = 0; i < 5; i++)
			push_value(value_t'(1) << (i * 7), i == 4);
		push_value(value_t'(31'h5555_5555), 1'b0);
		push_value(value_t'(31'h2AAA_AAAA), 1'b1);
	endtask

	task automatic test_capacity();
		// A batch that fills the store exactly, then one that runs past it
		// with the flagged last value itself dropped.
		for (int i = 0; i < CAPACITY; i++)
			push_value(rand_value(VAL_FULL), i == CAPACITY - 1);
		for (int i = 0; i < CAPACITY + 2; i++)
			push_value(rand_value(VAL_NARROW), i == CAPACITY + 1);
	endtask

	task automatic test_random_batches();
		int n;
		int step;
		int sent;
		value_t base;
		value_t v;
		value_kind_t kind;
		batch_order_t order;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(19, 0))
				0:       n = $urandom_range(CAPACITY + 4, CAPACITY - 2);
				1, 2, 3: n = $urandom_range(30, 11);
				default: n = $urandom_range(10, 1);
			endcase
			kind    = value_kind_t'($urandom_range(2, 0));
			order   = batch_order_t'($urandom_range(2, 0));
			no_idle = ($urandom_range(3, 0) == 0);
			base    = rand_value(kind);
			step    = $urandom_range(5000, 0);
			for (int i = 0; i < n; i++) begin
				case (order)
					ORD_ASCENDING:  v = base + value_t'(i * step);
					ORD_DESCENDING: v = base - value_t'(i * step);
					default:        v = rand_value(kind);
				endcase
				push_value(v, i == n - 1);
			end
			sent += n;
		end
		no_idle = 1'b0;
	endtask

	task automatic wait_for_drain();
		start <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		value        = '0;
		last_in      = 1'b0;
		held_ovf     = 1'b0;
		err_count    = 0;
		results_seen = 0;
		items_sent   = 0;
		batches_done = 0;
		ovf_batches  = 0;
		cycle_count  = 0;
		no_idle      = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_item_batches();
		test_ordering_and_duplicates();
		test_capacity();
		test_random_batches();
		wait_for_drain();

		$display("Sent %0d values in %0d batches (%0d over capacity); checked %0d results.",
			items_sent, batches_done, ovf_batches, results_seen);
		if (err_count == 0 && expected_q.size() == 0) begin
			$display("merge_insertion_sorter: match");
		end else begin
			$display("merge_insertion_sorter: mismatch");
		end
		$finish;
	end

endmodule
